[hw/rtl/lfct_pkg.sv]
`default_nettype none

package lfct_pkg;

    // target store geometry
    localparam int NUM_TARGETS = 8;
    localparam int TGT_IDX_W   = 3;
    localparam int MASK_W      = 8;

    // field widths
    localparam int STREAK_W = 8;
    localparam int CD_W     = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [STREAK_W-1:0] STREAK_MAX = 8'd255;

    // request codes
    localparam logic [1:0] REQ_COMPLETION = 2'd0;
    localparam logic [1:0] REQ_TICK       = 2'd1;
    localparam logic [1:0] REQ_QUERY      = 2'd2;

    // result codes
    localparam logic [1:0] RES_NONE    = 2'd0;
    localparam logic [1:0] RES_SUCCESS = 2'd1;
    localparam logic [1:0] RES_TIMEOUT = 2'd2;
    localparam logic [1:0] RES_EOF     = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EOF_THR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EOF_LEN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_MASK    = 3'd4;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [TGT_IDX_W-1:0] target_idx;
        logic                 entry_valid;
        logic                 result_present;
        logic [1:0]           result_code;
        logic                 periodic;
        logic                 is_data_request;
    } t_item_in;

    typedef struct packed {
        logic                 target_ok;
        logic                 cooldown_active;
        logic [STREAK_W-1:0]  streak_now;
        logic [CD_W-1:0]      cooldown_left;
        logic                 seen_result;
        logic [1:0]           recent_result;
        logic                 cooldown_started;
        logic [MASK_W-1:0]    cooldown_ended_mask;
    } t_item_out;

    typedef struct packed {
        logic [STREAK_W-1:0] timeout_thr;
        logic [STREAK_W-1:0] eof_thr;
        logic [CD_W-1:0]     timeout_len;
        logic [CD_W-1:0]     eof_len;
        logic [MASK_W-1:0]   tgt_mask;
    } t_cfg;

endpackage

`default_nettype wire

[hw/rtl/link_failure_cooldown_tracker_unit.sv]
`default_nettype none
// an item taken in the input register gives its result strobe from the result register
// throughput: one item per cycle, busy never rises; the state update is one registered pass
// results are shown for one cycle only, the receiver cannot stall
// reset (synchronous, active low) clears all target stores and loads register defaults
// no clearing pass is needed after reset

module link_failure_cooldown_tracker_unit
    import lfct_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_item_in             i_item,
    output logic                      o_res_valid,
    output t_item_out                 o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg cfg;

    logic          r_item_vld;
    t_item_in      r_item;
    logic          r_res_valid;
    t_item_out     r_res;

    logic [STREAK_W-1:0] r_streak [NUM_TARGETS];
    logic [CD_W-1:0]     r_cd     [NUM_TARGETS];
    logic                r_seen   [NUM_TARGETS];
    logic [1:0]          r_last   [NUM_TARGETS];

    logic [STREAK_W-1:0] n_streak [NUM_TARGETS];
    logic [CD_W-1:0]     n_cd     [NUM_TARGETS];
    logic                n_seen   [NUM_TARGETS];
    logic [1:0]          n_last   [NUM_TARGETS];
    t_item_out           n_res;

    logic                tracked;
    logic                go;
    logic                is_success;
    logic                is_fail;
    logic                is_eof;
    logic [STREAK_W-1:0] thr;
    logic [CD_W-1:0]     len;
    logic [STREAK_W-1:0] sel_streak;
    logic [CD_W-1:0]     sel_cd;
    logic                sel_seen;
    logic [1:0]          sel_last;
    logic                started;
    logic [MASK_W-1:0]   ended;

    lfct_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign busy = 1'b0;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
        end else begin
            r_item_vld <= start && !busy;
        end
        r_item <= i_item;
    end

    // decode of the registered item
    always_comb begin
        tracked = 1'b0;
        for (int i = 0; i < NUM_TARGETS; i++) begin
            if (i < MASK_W && r_item.target_idx == TGT_IDX_W'(i)) begin
                tracked = cfg.tgt_mask[i];
            end
        end
        go         = r_item_vld && r_item.req_type == REQ_COMPLETION
                     && r_item.entry_valid && r_item.result_present && tracked;
        is_success = go && r_item.result_code == RES_SUCCESS;
        is_fail    = go && !is_success && r_item.periodic && r_item.is_data_request;
        is_eof     = r_item.result_code == RES_EOF;
        thr        = is_eof ? cfg.eof_thr : cfg.timeout_thr;
        len        = is_eof ? cfg.eof_len : cfg.timeout_len;
    end

    // per-target next state, all entries in parallel
    always_comb begin
        started = 1'b0;
        ended   = '0;
        for (int i = 0; i < NUM_TARGETS; i++) begin
            n_streak[i] = r_streak[i];
            n_cd[i]     = r_cd[i];
            n_seen[i]   = r_seen[i];
            n_last[i]   = r_last[i];
            if (r_item.target_idx == TGT_IDX_W'(i) && i < (1 << TGT_IDX_W)) begin
                if (is_success) begin
                    n_seen[i]   = 1'b1;
                    n_last[i]   = RES_SUCCESS;
                    n_streak[i] = '0;
                    n_cd[i]     = '0;
                end else if (is_fail) begin
                    n_seen[i] = 1'b1;
                    n_last[i] = r_item.result_code;
                    if (r_streak[i] != STREAK_MAX) begin
                        n_streak[i] = r_streak[i] + STREAK_W'(1);
                    end
                    if (n_streak[i] >= thr && r_cd[i] == '0) begin
                        n_cd[i] = len;
                        started = len != '0;
                    end
                end
            end
            // tick counts down running cooldowns
            if (r_item_vld && r_item.req_type == REQ_TICK && r_cd[i] != '0) begin
                n_cd[i] = r_cd[i] - CD_W'(1);
                if (r_cd[i] == CD_W'(1)) begin
                    n_streak[i] = '0;
                    if (i < MASK_W) begin
                        ended[i] = 1'b1;
                    end
                end
            end
        end
    end

    // status of the addressed target after the update, or the ended mask for a tick
    always_comb begin
        sel_streak = '0;
        sel_cd     = '0;
        sel_seen   = 1'b0;
        sel_last   = RES_NONE;
        for (int i = 0; i < NUM_TARGETS; i++) begin
            if (r_item.target_idx == TGT_IDX_W'(i) && i < (1 << TGT_IDX_W)) begin
                sel_streak = n_streak[i];
                sel_cd     = n_cd[i];
                sel_seen   = n_seen[i];
                sel_last   = n_last[i];
            end
        end
        n_res = '0;
        case (r_item.req_type) inside
            REQ_COMPLETION, REQ_QUERY: begin
                if (tracked) begin
                    n_res.target_ok       = 1'b1;
                    n_res.cooldown_active = sel_cd != '0;
                    n_res.streak_now      = sel_streak;
                    n_res.cooldown_left   = sel_cd;
                    n_res.seen_result     = sel_seen;
                    n_res.recent_result   = sel_last;
                end
                n_res.cooldown_started = started;
            end
            REQ_TICK: n_res.cooldown_ended_mask = ended;
            default: begin
            end
        endcase
    end

    // target stores and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            for (int i = 0; i < NUM_TARGETS; i++) begin
                r_streak[i] <= '0;
                r_cd[i]     <= '0;
                r_seen[i]   <= 1'b0;
                r_last[i]   <= RES_NONE;
            end
        end else begin
            r_res_valid <= r_item_vld;
            for (int i = 0; i < NUM_TARGETS; i++) begin
                r_streak[i] <= n_streak[i];
                r_cd[i]     <= n_cd[i];
                r_seen[i]   <= n_seen[i];
                r_last[i]   <= n_last[i];
            end
        end
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

[hw/rtl/lfct_cfg_regs.sv]
`default_nettype none

module lfct_cfg_regs
    import lfct_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    // register writes, out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_thr <= STREAK_W'(3);
            r_cfg.eof_thr     <= STREAK_W'(3);
            r_cfg.timeout_len <= CD_W'(100);
            r_cfg.eof_len     <= CD_W'(100);
            r_cfg.tgt_mask    <= MASK_W'(31);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEOUT_THR: r_cfg.timeout_thr <= i_cfg_data[STREAK_W-1:0];
                CFG_EOF_THR:     r_cfg.eof_thr     <= i_cfg_data[STREAK_W-1:0];
                CFG_TIMEOUT_LEN: r_cfg.timeout_len <= i_cfg_data[CD_W-1:0];
                CFG_EOF_LEN:     r_cfg.eof_len     <= i_cfg_data[CD_W-1:0];
                CFG_TGT_MASK:    r_cfg.tgt_mask    <= i_cfg_data[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire
